>>> sv/chm_pkg.sv
package chm_pkg;

  // Table geometry.
  localparam int BUCKETS  = 256;
  localparam int NODES    = 256;
  localparam int HASH_W   = 32;
  localparam int VALUE_W  = 32;

  // Derived widths.
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int NODE_AW  = $clog2(NODES);
  localparam int LINK_W   = $clog2(NODES + 1);
  localparam int USED_W   = LINK_W;
  localparam int COUNT_W  = $clog2(BUCKETS + NODES + 1);
  localparam int STATUS_W = 3;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Operation codes.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FIND  = 1'b1
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_WALK
  } state_e;

  // One stored entry: key, value and link to the next chain node (zero ends the chain).
  typedef struct packed {
    logic [HASH_W-1:0]  key;
    logic [VALUE_W-1:0] data;
    logic [LINK_W-1:0]  link;
  } entry_t;

  // Access request to the chain node pool.
  typedef struct packed {
    logic               rd_en;
    logic [NODE_AW-1:0] rd_addr;
    logic               wr_en;
    logic [NODE_AW-1:0] wr_addr;
    entry_t             wr_entry;
  } node_req_t;

endpackage

>>> sv/chm_node_mem.sv
module chm_node_mem (
  input  logic               clk_i,
  input  chm_pkg::node_req_t req_i,
  output chm_pkg::entry_t    rd_entry_o
);
  import chm_pkg::*;

  entry_t node_mem_q [NODES];
  entry_t rd_entry_q;

  // Pool storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      node_mem_q[req_i.wr_addr] <= req_i.wr_entry;
    end
    if (req_i.rd_en) begin
      rd_entry_q <= node_mem_q[req_i.rd_addr];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

>>> sv/chained_hash_map_unit.sv
// A taken start loads the head entry and enters the head step; the walk then reads the node
// pool one node per cycle until the key matches or the chain runs out; done_o is registered.
// busy is high while a word is at work; a new word is taken only once busy has dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears the sequencer, the head-valid bits and both counts.
module chained_hash_map_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [chm_pkg::HASH_W-1:0]    key_hash_i,
  input  logic [chm_pkg::VALUE_W-1:0]   data_value_i,
  output logic                          done_o,
  output logic [chm_pkg::STATUS_W-1:0]  status_o,
  output logic [chm_pkg::VALUE_W-1:0]   read_value_o,
  output logic [chm_pkg::COUNT_W-1:0]   stored_count_o
);
  import chm_pkg::*;

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [HASH_W-1:0]    key_q;
  logic [VALUE_W-1:0]   val_q;
  logic [USED_W-1:0]    nodes_used_q;
  logic [COUNT_W-1:0]   count_q;
  logic                 head_valid_q [BUCKETS];
  logic [NODE_AW-1:0]   cur_node_q;
  logic                 done_q;
  status_e              status_q;
  logic [VALUE_W-1:0]   rv_q;

  entry_t               head_mem_q [BUCKETS];
  entry_t               head_rd_q;
  entry_t               node_rd;
  node_req_t            node_req;

  logic                 accept;
  logic [BKT_W-1:0]     bucket;
  entry_t               cmp_entry;
  logic                 key_match;
  logic                 link_ok;
  logic [LINK_W-1:0]    link_m1;
  logic                 head_live;
  logic                 pool_full;
  logic                 finish;

  logic                 head_we;
  entry_t               head_wdata;
  logic                 set_valid;
  logic                 used_inc;
  logic                 count_inc;
  status_e              res_status;
  logic [VALUE_W-1:0]   res_value;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign bucket = key_q[BKT_W-1:0];

  // Shared compare unit: head entry in the head step, pool node in the walk.
  assign cmp_entry = (state_q == S_HEAD) ? head_rd_q : node_rd;
  assign key_match = (cmp_entry.key == key_q);
  assign link_ok   = (cmp_entry.link != '0) && (cmp_entry.link <= nodes_used_q);
  assign link_m1   = cmp_entry.link - LINK_W'(1);
  assign head_live = head_valid_q[bucket];
  assign pool_full = (nodes_used_q >= USED_W'(NODES));

  // The word is finished when the key is matched or the chain runs out.
  always_comb begin
    unique case (state_q)
      S_HEAD:  finish = !head_live || key_match || !link_ok;
      S_WALK:  finish = key_match || !link_ok;
      default: finish = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_HEAD;
      S_HEAD,
      S_WALK:  state_d = finish ? S_IDLE : S_WALK;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory controls and result selection.
  always_comb begin
    head_we    = 1'b0;
    head_wdata = '{key: key_q, data: val_q, link: '0};
    set_valid  = 1'b0;
    used_inc   = 1'b0;
    count_inc  = 1'b0;
    res_status = ST_NOT_FOUND;
    res_value  = '0;
    node_req   = '{rd_en: 1'b0, rd_addr: link_m1[NODE_AW-1:0], wr_en: 1'b0,
                   wr_addr: cur_node_q,
                   wr_entry: '{key: cmp_entry.key, data: val_q, link: cmp_entry.link}};
    if ((state_q == S_HEAD) && !head_live) begin
      // Empty bucket: a write claims the head slot.
      if (op_q == OP_WRITE) begin
        head_we    = 1'b1;
        set_valid  = 1'b1;
        count_inc  = 1'b1;
        res_status = ST_INSERTED;
      end
    end else if ((state_q == S_HEAD) || (state_q == S_WALK)) begin
      if (key_match) begin
        if (op_q == OP_FIND) begin
          res_status = ST_FOUND;
          res_value  = cmp_entry.data;
        end else begin
          res_status = ST_REPLACED;
          if (state_q == S_HEAD) begin
            head_we    = 1'b1;
            head_wdata = '{key: head_rd_q.key, data: val_q, link: head_rd_q.link};
          end else begin
            node_req.wr_en = 1'b1;
          end
        end
      end else if (link_ok) begin
        node_req.rd_en = 1'b1;
      end else if (op_q == OP_WRITE) begin
        // Chain exhausted: link a new node in just after the head.
        if (pool_full) begin
          res_status = ST_FULL;
        end else begin
          node_req.wr_en    = 1'b1;
          node_req.wr_addr  = nodes_used_q[NODE_AW-1:0];
          node_req.wr_entry = '{key: key_q, data: val_q, link: head_rd_q.link};
          head_we    = 1'b1;
          head_wdata = '{key: head_rd_q.key, data: head_rd_q.data,
                         link: nodes_used_q + USED_W'(1)};
          used_inc   = 1'b1;
          count_inc  = 1'b1;
          res_status = ST_INSERTED;
        end
      end
    end
  end

  // Head slot storage with registered read at accept.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem_q[bucket] <= head_wdata;
    end
    if (accept) begin
      head_rd_q <= head_mem_q[key_hash_i[BKT_W-1:0]];
    end
  end

  chm_node_mem u_node_mem (
    .clk_i      (clk_i),
    .req_i      (node_req),
    .rd_entry_o (node_rd)
  );

  // Word capture and node tracking.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      key_q <= key_hash_i;
      val_q <= data_value_i;
    end
    if (node_req.rd_en) begin
      cur_node_q <= node_req.rd_addr;
    end
    if (finish) begin
      status_q <= res_status;
      rv_q     <= res_value;
    end
  end

  // Control state and counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      nodes_used_q <= '0;
      count_q      <= '0;
      for (int i = 0; i < BUCKETS; i++) begin
        head_valid_q[i] <= 1'b0;
      end
    end else begin
      state_q      <= state_d;
      done_q       <= finish;
      nodes_used_q <= nodes_used_q + USED_W'(used_inc);
      count_q      <= count_q + COUNT_W'(count_inc);
      if (set_valid) begin
        head_valid_q[bucket] <= 1'b1;
      end
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign read_value_o   = rv_q;
  assign stored_count_o = count_q;

`ifndef NO_ASSERTIONS
  // A result is shown only once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // A taken word always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not start");

  // The pool is never handed out beyond its size.
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_used_q <= USED_W'(NODES))
    else $error("node pool overrun");

  // The entry count moves only when a result is produced.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> done_o)
    else $error("entry count changed without a result");
`endif

endmodule

>>> tb/chained_hash_map_unit_tb.sv
module chained_hash_map_unit_tb;
  import chm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 300;

  // One result word as the block should report it.
  typedef struct {
    status_e            status;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } map_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                operation_i;
  logic [HASH_W-1:0]   key_hash_i;
  logic [VALUE_W-1:0]  data_value_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [VALUE_W-1:0]  read_value_o;
  logic [COUNT_W-1:0]  stored_count_o;

  // Shadow copy of the table contents.
  logic               tbl_head_valid [BUCKETS];
  logic [HASH_W-1:0]  tbl_head_key   [BUCKETS];
  logic [VALUE_W-1:0] tbl_head_data  [BUCKETS];
  logic [LINK_W-1:0]  tbl_head_link  [BUCKETS];
  logic [HASH_W-1:0]  pool_key       [NODES];
  logic [VALUE_W-1:0] pool_data      [NODES];
  logic [LINK_W-1:0]  pool_link      [NODES];
  logic [USED_W-1:0]  pool_used;
  logic [COUNT_W-1:0] stored_keys;

  map_result_t       pending_results[$];
  logic [HASH_W-1:0] known_keys[$];
  int                fail_count;
  int                burst_left;
  int                idle_cycles;

  chained_hash_map_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .key_hash_i     (key_hash_i),
    .data_value_i   (data_value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .stored_count_o (stored_count_o)
  );

  // Free-running clock, period 20.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Walk a chain from the given link and return the link of the node holding the key,
  // or zero when the key is not in the chain.
  function automatic logic [LINK_W-1:0] chain_search(logic [LINK_W-1:0] link,
                                                     logic [HASH_W-1:0] key);
    int                 steps;
    logic [LINK_W-1:0]  hit;
    logic [NODE_AW-1:0] idx;
    steps = 0;
    hit   = '0;
    while (hit == '0 && link != '0 && link <= pool_used && steps < NODES) begin
      idx = NODE_AW'(link - 1'b1);
      if (pool_key[idx] == key) begin
        hit = link;
      end else begin
        link = pool_link[idx];
        steps++;
      end
    end
    return hit;
  endfunction

  // Apply one word to the shadow table and return the result it should produce.
  function automatic map_result_t hash_map_apply(op_e op, logic [HASH_W-1:0] key,
                                                 logic [VALUE_W-1:0] value);
    map_result_t        res;
    logic [BKT_W-1:0]   bkt;
    logic [LINK_W-1:0]  hit;
    logic [NODE_AW-1:0] slot;
    bkt        = key[BKT_W-1:0];
    res.status = ST_NOT_FOUND;
    res.value  = '0;
    if (op == OP_FIND) begin
      if (tbl_head_valid[bkt]) begin
        if (tbl_head_key[bkt] == key) begin
          res.status = ST_FOUND;
          res.value  = tbl_head_data[bkt];
        end else begin
          hit = chain_search(tbl_head_link[bkt], key);
          if (hit != '0) begin
            slot       = NODE_AW'(hit - 1'b1);
            res.status = ST_FOUND;
            res.value  = pool_data[slot];
          end
        end
      end
    end else if (!tbl_head_valid[bkt]) begin
      // Empty bucket: the key takes the head slot.
      tbl_head_valid[bkt] = 1'b1;
      tbl_head_key[bkt]   = key;
      tbl_head_data[bkt]  = value;
      tbl_head_link[bkt]  = '0;
      stored_keys++;
      known_keys.push_back(key);
      res.status = ST_INSERTED;
    end else if (tbl_head_key[bkt] == key) begin
      tbl_head_data[bkt] = value;
      res.status = ST_REPLACED;
    end else begin
      hit = chain_search(tbl_head_link[bkt], key);
      if (hit != '0) begin
        slot            = NODE_AW'(hit - 1'b1);
        pool_data[slot] = value;
        res.status = ST_REPLACED;
      end else if (pool_used >= NODES) begin
        res.status = ST_FULL;
      end else begin
        // New node goes right behind the head.
        slot            = pool_used[NODE_AW-1:0];
        pool_key[slot]  = key;
        pool_data[slot] = value;
        pool_link[slot] = tbl_head_link[bkt];
        tbl_head_link[bkt]   = pool_used + 1'b1;
        pool_used++;
        stored_keys++;
        known_keys.push_back(key);
        res.status = ST_INSERTED;
      end
    end
    res.count = stored_keys;
    return res;
  endfunction

  // Send one word, with the sender pausing between bursts of random length.
  task automatic send_word(op_e op, logic [HASH_W-1:0] key, logic [VALUE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start        <= 1'b1;
    operation_i  <= op;
    key_hash_i   <= key;
    data_value_i <= value;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(hash_map_apply(op, key, value));
  endtask

  // Pick a key that is already held, or a fresh one when none is.
  function automatic logic [HASH_W-1:0] held_key(logic [HASH_W-1:0] fallback);
    if (known_keys.size() == 0) begin
      return fallback;
    end
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Finds on an empty table, at both ends of the key range.
  task automatic test_empty_table();
    send_word(OP_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(OP_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Head slots: fill, find, replace, and miss on a different key in a used bucket.
  task automatic test_head_slots();
    send_word(OP_WRITE, 32'h0000_0000, 32'h0000_0000);
    send_word(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_FIND,  32'h0000_0000, 32'h0000_0000);
    send_word(OP_FIND,  32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(OP_FIND,  32'h0000_0000, 32'h1234_5678);
    send_word(OP_FIND,  32'h0000_0100, 32'h0000_0000);
  endtask

  // Chain nodes in one bucket: link in, find, replace a deep node, miss after a full walk.
  task automatic test_chain_links();
    send_word(OP_WRITE, 32'h0000_0100, 32'hAAAA_5555);
    send_word(OP_WRITE, 32'h8000_0000, 32'h5555_AAAA);
    send_word(OP_WRITE, 32'h7FFF_FF00, 32'h0F0F_F0F0);
    send_word(OP_FIND,  32'h0000_0100, 32'h0000_0000);
    send_word(OP_FIND,  32'h8000_0000, 32'h0000_0000);
    send_word(OP_FIND,  32'h7FFF_FF00, 32'h0000_0000);
    send_word(OP_WRITE, 32'h0000_0100, 32'hDEAD_BEEF);
    send_word(OP_FIND,  32'h0000_0100, 32'h0000_0000);
    send_word(OP_FIND,  32'hDEAD_BE00, 32'h0000_0000);
    send_word(OP_FIND,  32'h0000_0000, 32'h0000_0000);
  endtask

  // Mixed traffic crowded into sixteen buckets so chains grow and keys repeat.
  task automatic test_crowded_buckets(int count);
    int                pick;
    logic [HASH_W-1:0] fresh;
    for (int i = 0; i < count; i++) begin
      pick  = $urandom_range(0, 99);
      fresh = $urandom() & 32'hFFFF_FF0F;
      if (pick < 35) begin
        send_word(OP_FIND, held_key(fresh), $urandom());
      end else if (pick < 45) begin
        send_word(OP_FIND, fresh, $urandom());
      end else if (pick < 85) begin
        send_word(OP_WRITE, held_key(fresh), $urandom());
      end else begin
        send_word(OP_WRITE, fresh, $urandom());
      end
    end
  endtask

  // Spread traffic over all buckets until the node pool runs out and writes are refused.
  task automatic test_pool_exhaustion(int count);
    int                pick;
    logic [HASH_W-1:0] fresh;
    for (int i = 0; i < count; i++) begin
      pick  = $urandom_range(0, 99);
      fresh = $urandom();
      if (pick < 60) begin
        send_word(OP_WRITE, fresh, $urandom());
      end else if (pick < 75) begin
        send_word(OP_WRITE, held_key(fresh), $urandom());
      end else if (pick < 90) begin
        send_word(OP_FIND, held_key(fresh), $urandom());
      end else begin
        send_word(OP_FIND, fresh, $urandom());
      end
    end
  endtask

  // Compare each result word with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    map_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d value %h count %0d",
                 $time, status_o, read_value_o, stored_count_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          fail_count++;
        end
        if (read_value_o !== want.value) begin
          $display("%0t: read_value expected %h, got %h", $time, want.value, read_value_o);
          fail_count++;
        end
        if (stored_count_o !== want.count) begin
          $display("%0t: stored_count expected %0d, got %0d",
                   $time, want.count, stored_count_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, run each test in turn, drain and report.
  initial begin
    fail_count  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    pool_used   = '0;
    stored_keys = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      tbl_head_valid[i] = 1'b0;
    end
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    operation_i  <= OP_WRITE;
    key_hash_i   <= '0;
    data_value_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_head_slots();
    test_chain_links();
    test_crowded_buckets(900);
    test_pool_exhaustion(1000);

    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/chm_pkg.sv
sv/chm_node_mem.sv
sv/chained_hash_map_unit.sv
tb/chained_hash_map_unit_tb.sv
